FILE: sv/owtsd_pkg.sv
package owtsd_pkg;

   localparam int ByteWidth = 8;
   localparam int TempWidth = 12;
   localparam int IndexWidth = 4;

   localparam logic [ByteWidth-1:0] FamilyA = 8'h10;
   localparam logic [ByteWidth-1:0] FamilyB = 8'h28;
   localparam logic [ByteWidth-1:0] SignMask = 8'hF8;
   localparam logic [ByteWidth-1:0] AllOnes = 8'hFF;
   localparam logic [ByteWidth-1:0] CrcPoly = 8'h8C;
   localparam logic [IndexWidth-1:0] CrcIndex = 4'd8;
   localparam logic signed [TempWidth-1:0] UnknownTemp = 12'sd255;

   localparam logic StatusOk = 1'b0;
   localparam logic StatusBadCrc = 1'b1;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic signed [TempWidth-1:0] temp_type;

   // 1-Wire CRC-8, one byte, reflected polynomial
   function automatic byte_type crc_update(input byte_type crc, input byte_type b);
      byte_type c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

FILE: sv/owtsd_req_if.sv
interface owtsd_req_if;
   logic valid;
   logic ready;
   owtsd_pkg::byte_type data_byte;
   owtsd_pkg::byte_type family_code;

   modport source(output valid, output data_byte, output family_code, input ready);
   modport sink(input valid, input data_byte, input family_code, output ready);
endinterface

FILE: sv/owtsd_rsp_if.sv
interface owtsd_rsp_if;
   logic valid;
   logic ready;
   logic status;
   owtsd_pkg::temp_type temperature_tenths;

   modport source(output valid, output status, output temperature_tenths, input ready);
   modport sink(input valid, input status, input temperature_tenths, output ready);
endinterface

FILE: sv/onewire_temp_scratchpad_decode.sv
// 1-Wire temperature scratchpad decoder.
// req_chan: one scratchpad word per transfer (data_byte, family_code), byte 0
// first, byte 8 is the CRC. family_code is only looked at with byte 8.
// rsp_chan: one word per nine input words (status, temperature_tenths).
// status 1 means CRC mismatch and the temperature reads zero.
// A result word comes out of the result register: the ninth input word is
// loaded into the input register when taken and moves on into the result
// register once that register is free.
// Throughput: one input word per cycle while no ninth word waits; the CRC
// step and decode sit in the single logic stage between the two registers.
// Reset (synchronous, active high) empties both registers and restarts at
// byte 0 with a cleared CRC.
// When rsp_chan stalls, the result register holds its word; the input
// register keeps moving bytes 0..7 through, and a ninth byte waits there,
// holding req_chan.ready low, until the result register frees up.
module onewire_temp_scratchpad_decode (
   input logic clock,
   input logic reset,
   owtsd_req_if.sink req_chan,
   owtsd_rsp_if.source rsp_chan
);

   logic s1_valid_ff, s1_valid_in;
   owtsd_pkg::byte_type s1_byte_ff, s1_family_ff;

   logic [owtsd_pkg::IndexWidth-1:0] index_ff, index_in;
   owtsd_pkg::byte_type crc_ff, crc_in;
   owtsd_pkg::byte_type lo_ff, lo_in, hi_ff, hi_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic status_ff, status_in;
   owtsd_pkg::temp_type temp_ff, temp_in;

   logic is_last, out_free, s1_adv, req_take;
   owtsd_pkg::temp_type decoded;

   // decode temporaries
   owtsd_pkg::byte_type diff;
   logic [10:0] lo5, diff5, mag;
   logic [15:0] raw, rawn;
   logic [14:0] m10;
   logic neg;

   assign is_last = (index_ff >= owtsd_pkg::CrcIndex);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_adv = s1_valid_ff && (!is_last || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.temperature_tenths = temp_ff;

   always_comb begin
      lo5 = {1'b0, lo_ff, 2'b00} + {3'b000, lo_ff};
      diff = ~lo_ff;
      diff5 = {1'b0, diff, 2'b00} + {3'b000, diff};
      raw = {hi_ff, lo_ff};
      neg = |(hi_ff & owtsd_pkg::SignMask);
      rawn = neg ? (~raw + 16'd1) : raw;
      m10 = {1'b0, rawn[10:0], 3'b000} + {3'b000, rawn[10:0], 1'b0};
      mag = m10[14:4];
      if (s1_family_ff == owtsd_pkg::FamilyA) begin
         if (hi_ff != owtsd_pkg::AllOnes) begin
            decoded = owtsd_pkg::temp_type'({1'b0, lo5});
         end else begin
            decoded = -owtsd_pkg::temp_type'({1'b0, diff5});
         end
      end else if (s1_family_ff == owtsd_pkg::FamilyB) begin
         decoded = neg ? -owtsd_pkg::temp_type'({1'b0, mag})
                       : owtsd_pkg::temp_type'({1'b0, mag});
      end else begin
         decoded = owtsd_pkg::UnknownTemp;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      index_in = index_ff;
      crc_in = crc_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in = status_ff;
      temp_in = temp_ff;

      if (s1_adv) begin
         if (!is_last) begin
            if (index_ff == 4'd0) begin
               lo_in = s1_byte_ff;
            end
            if (index_ff == 4'd1) begin
               hi_in = s1_byte_ff;
            end
            crc_in = owtsd_pkg::crc_update(crc_ff, s1_byte_ff);
            index_in = index_ff + 4'd1;
         end else begin
            rsp_valid_in = 1'b1;
            if (crc_ff == s1_byte_ff) begin
               status_in = owtsd_pkg::StatusOk;
               temp_in = decoded;
            end else begin
               status_in = owtsd_pkg::StatusBadCrc;
               temp_in = '0;
            end
            index_in = '0;
            crc_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         index_ff <= '0;
         crc_ff <= '0;
         lo_ff <= '0;
         hi_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         index_ff <= index_in;
         crc_ff <= crc_in;
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_family_ff <= req_chan.family_code;
      end
      status_ff <= status_in;
      temp_ff <= temp_in;
   end

endmodule

FILE: sim/scratchpad_reading_checker.sv
module scratchpad_reading_checker (
   input  logic   clock,
   input  logic   reset,
   owtsd_req_if   req_mon,
   owtsd_rsp_if   rsp_mon,
   output int     error_count,
   output int     readings_pending,
   output int     readings_checked,
   output int     crc_errors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                status;
      owtsd_pkg::temp_type tenths;
   } reading_type;

   reading_type expected_readings[$];

   logic [owtsd_pkg::IndexWidth-1:0] word_index;
   owtsd_pkg::byte_type              crc_run;
   owtsd_pkg::byte_type              temp_lsb;
   owtsd_pkg::byte_type              temp_msb;

   // 1-Wire CRC-8, one input bit at a time, LSB first
   function automatic owtsd_pkg::byte_type crc8_next(input owtsd_pkg::byte_type crc,
                                                     input owtsd_pkg::byte_type b);
      owtsd_pkg::byte_type c;
      logic                mix;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ b[i];
         c = c >> 1;
         if (mix) begin
            c = c ^ owtsd_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic owtsd_pkg::temp_type tenths_for(input owtsd_pkg::byte_type family,
                                                      input owtsd_pkg::byte_type lsb,
                                                      input owtsd_pkg::byte_type msb);
      logic [15:0] raw;
      logic        negative;
      int          mag;
      if (family == owtsd_pkg::FamilyA) begin
         if (msb != owtsd_pkg::AllOnes) begin
            return owtsd_pkg::temp_type'(int'(lsb) * 5);
         end
         return owtsd_pkg::temp_type'(-(int'(owtsd_pkg::AllOnes - lsb) * 5));
      end
      if (family == owtsd_pkg::FamilyB) begin
         raw = {msb, lsb};
         negative = (msb & owtsd_pkg::SignMask) != '0;
         if (negative) begin
            raw = -raw;
         end
         mag = (10 * int'(raw[10:0])) / 16;
         return negative ? owtsd_pkg::temp_type'(-mag) : owtsd_pkg::temp_type'(mag);
      end
      return owtsd_pkg::UnknownTemp;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : track
      reading_type want;
      if (reset) begin
         word_index <= '0;
         crc_run <= '0;
         temp_lsb <= '0;
         temp_msb <= '0;
         expected_readings.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (word_index < owtsd_pkg::CrcIndex) begin
               if (word_index == 0) begin
                  temp_lsb <= req_mon.data_byte;
               end else if (word_index == 1) begin
                  temp_msb <= req_mon.data_byte;
               end
               crc_run <= crc8_next(crc_run, req_mon.data_byte);
               word_index <= word_index + 1'b1;
            end else begin
               if (crc_run == req_mon.data_byte) begin
                  expected_readings.push_back({owtsd_pkg::StatusOk,
                     tenths_for(req_mon.family_code, temp_lsb, temp_msb)});
               end else begin
                  expected_readings.push_back({owtsd_pkg::StatusBadCrc,
                     owtsd_pkg::temp_type'(0)});
               end
               word_index <= '0;
               crc_run <= '0;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch($sformatf("unexpected reading status=%0b tenths=%0d",
                  rsp_mon.status, rsp_mon.temperature_tenths));
            end else begin
               want = expected_readings.pop_front();
               readings_checked++;
               if (want.status == owtsd_pkg::StatusBadCrc) begin
                  crc_errors_seen++;
               end
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("reading %0d status %0b, want %0b",
                     readings_checked, rsp_mon.status, want.status));
               end
               if (rsp_mon.temperature_tenths !== want.tenths) begin
                  report_mismatch($sformatf("reading %0d tenths %0d, want %0d",
                     readings_checked, rsp_mon.temperature_tenths, want.tenths));
               end
            end
         end
      end
      readings_pending = expected_readings.size();
   end

endmodule

FILE: sim/onewire_temp_scratchpad_decode_test.sv
module onewire_temp_scratchpad_decode_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit = 200000;
   localparam int HoldCycles = 300;
   localparam int PhaseFrames = 30;
   localparam int PressureFrames = 12;

   logic clock = 1'b0;
   logic reset;

   int error_count;
   int readings_pending;
   int readings_checked;
   int crc_errors_seen;

   int   cycle_count;
   int   words_sent;
   int   idle_pct;
   int   stall_pct;
   int   hold_count;
   logic hold_enable;

   int idle_mix[4]  = '{0, 74, 0, 24};
   int stall_mix[4] = '{0, 0, 74, 24};

   owtsd_req_if req_chan();
   owtsd_rsp_if rsp_chan();

   onewire_temp_scratchpad_decode dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   scratchpad_reading_checker reading_check (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_chan),
      .rsp_mon          (rsp_chan),
      .error_count      (error_count),
      .readings_pending (readings_pending),
      .readings_checked (readings_checked),
      .crc_errors_seen  (crc_errors_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Timeout after %0d cycles, %0d readings outstanding",
                  cycle_count, readings_pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_enable && hold_count < HoldCycles) begin
         rsp_chan.ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   function automatic owtsd_pkg::byte_type crc_step(input owtsd_pkg::byte_type crc,
                                                    input owtsd_pkg::byte_type b);
      owtsd_pkg::byte_type c;
      logic                mix;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ b[i];
         c = c >> 1;
         if (mix) begin
            c = c ^ owtsd_pkg::CrcPoly;
         end
      end
      return c;
   endfunction

   task automatic send_word(input owtsd_pkg::byte_type data, input owtsd_pkg::byte_type family);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= data;
      req_chan.family_code <= family;
      do @(posedge clock); while (!req_chan.ready);
      words_sent++;
   endtask

   task automatic send_frame(input owtsd_pkg::byte_type lsb, input owtsd_pkg::byte_type msb,
                             input owtsd_pkg::byte_type family, input logic corrupt);
      owtsd_pkg::byte_type frame[9];
      owtsd_pkg::byte_type crc;
      crc = '0;
      frame[0] = lsb;
      frame[1] = msb;
      for (int i = 2; i < 8; i++) begin
         frame[i] = owtsd_pkg::byte_type'($urandom_range(0, 255));
      end
      for (int i = 0; i < 8; i++) begin
         crc = crc_step(crc, frame[i]);
      end
      frame[8] = corrupt ? crc ^ owtsd_pkg::byte_type'($urandom_range(1, 255)) : crc;
      for (int i = 0; i < 9; i++) begin
         send_word(frame[i], (i == 8) ? family : owtsd_pkg::byte_type'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_random_frame();
      owtsd_pkg::byte_type family;
      owtsd_pkg::byte_type lsb;
      owtsd_pkg::byte_type msb;
      int                  pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         family = owtsd_pkg::FamilyA;
      end else if (pick < 8) begin
         family = owtsd_pkg::FamilyB;
      end else begin
         family = owtsd_pkg::byte_type'($urandom_range(0, 255));
      end
      lsb = owtsd_pkg::byte_type'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
         0: msb = '0;
         1: msb = owtsd_pkg::AllOnes;
         2: msb = $urandom_range(0, 1) ? owtsd_pkg::byte_type'($urandom_range(0, 7))
                                       : owtsd_pkg::byte_type'($urandom_range(248, 255));
         default: msb = owtsd_pkg::byte_type'($urandom_range(0, 255));
      endcase
      send_frame(lsb, msb, family, $urandom_range(0, 5) == 0);
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.family_code = '0;
      hold_enable = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // largest positive reading, most negative half-degree reading, bad CRC
      send_frame(owtsd_pkg::AllOnes, 8'h07, owtsd_pkg::FamilyB, 1'b0);
      send_frame('0, owtsd_pkg::AllOnes, owtsd_pkg::FamilyA, 1'b0);
      send_frame(owtsd_pkg::AllOnes, owtsd_pkg::AllOnes, owtsd_pkg::AllOnes, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = idle_mix[phase];
         stall_pct <= stall_mix[phase];
         for (int f = 0; f < PhaseFrames; f++) begin
            send_random_frame();
         end
         if (phase == 0) begin
            // output held off while input keeps coming, to back up the pipe
            hold_enable <= 1'b1;
            for (int f = 0; f < PressureFrames; f++) begin
               send_random_frame();
            end
            hold_enable <= 1'b0;
         end
      end

      req_chan.valid <= 1'b0;
      stall_pct <= 0;
      @(posedge clock);
      while (readings_pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d scratchpad words, checked %0d readings (%0d with CRC errors)",
               words_sent, readings_checked, crc_errors_seen);
      $display("under four sender/receiver idle mixes and one %0d-cycle output hold",
               HoldCycles);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
